// File: rtl/core/bezier_curve_evaluator_core_macros.svh
// Assertion macros for the Bezier curve evaluator core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BEZIER_CURVE_EVALUATOR_CORE_MACROS_SVH
`define BEZIER_CURVE_EVALUATOR_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define BCE_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset
`define BCE_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define BCE_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define BCE_ASSERT_NXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

// File: rtl/core/bce_pkg.sv
// Shared constants for the Bezier curve evaluator core.
// No dependencies; imported by the core, bce_lerp and the testbench.
`timescale 1ns / 1ps
package bce_pkg;
  localparam int MAX_POINTS_DEF      = 8;
  localparam int COORD_BITS_DEF      = 32;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  localparam int OUT_W    = 48;
  localparam int CNT_W    = 4;
  localparam int IDX_W    = 3;
  localparam int ORD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int KW       = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_T_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEGEN   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd3;

  localparam logic [ORD_W-1:0] ORD_POINT = 2'd0;
  localparam logic [ORD_W-1:0] ORD_FIRST = 2'd1;
  localparam logic [ORD_W-1:0] ORD_SECOND = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_RESET = 4'd2;
endpackage

// File: rtl/core/bce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bce_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/bce_lerp.sv
// Two-stage rounding lerp a + round((b - a) * t) for one coordinate.
// Depends on bce_pkg.
`timescale 1ns / 1ps
module bce_lerp #(
  parameter int WW   = 42,
  parameter int FRAC = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [WW-1:0] a,
  input  logic signed [WW-1:0] b,
  input  logic [FRAC:0]        t,
  output logic                 out_valid,
  output logic                 busy,
  output logic signed [WW-1:0] result
);
  import bce_pkg::*;

  localparam int PRW = WW + FRAC + 2;
  localparam logic signed [PRW-1:0] HALF = PRW'(64'd1 << (FRAC - 1));

  logic signed [WW:0]     diff;
  logic signed [PRW-1:0]  prod;
  logic signed [PRW-1:0]  rounded;
  logic signed [WW-1:0]   a_q;
  logic                   v1;

  assign diff    = (WW + 1)'(b) - (WW + 1)'(a);
  assign rounded = (prod + HALF) >>> FRAC;
  assign busy    = v1 | out_valid;

  // multiply stage, then round and add
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
    prod   <= diff * $signed({1'b0, t});
    a_q    <= a;
    result <= a_q + WW'(rounded);
  end
endmodule

// File: rtl/core/bezier_curve_evaluator_core.sv
// Bezier curve evaluator: de Casteljau over control points held in RAM.
// Write item: stores the point and returns its status. Evaluate: a load pass over
// the n points, then one lerp sweep per level L (m-1 down to 1), then readout.
// One item at a time. Reset is synchronous; control points stay undefined.
// Depends on bce_pkg, bce_ram, bce_lerp and the macros header.
`timescale 1ns / 1ps
`include "bezier_curve_evaluator_core_macros.svh"
module bezier_curve_evaluator_core #(
  parameter int MAX_POINTS      = bce_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS      = bce_pkg::COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = bce_pkg::PARAM_FRAC_BITS_DEF,
  localparam int DIN_BITS = bce_pkg::IDX_W + 2 * COORD_BITS + PARAM_FRAC_BITS + 1
                            + bce_pkg::ORD_W,
  localparam int DIN_W    = ((DIN_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bce_pkg::CNT_W-1:0]      cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // point_index, point_x, point_y, param_t, deriv_order, zero fill
  input  logic [DIN_W-1:0]               s_axis_tdata,
  // opcode
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_x, result_y
  output logic [2*bce_pkg::OUT_W-1:0]    m_axis_tdata,
  // status
  output logic [bce_pkg::STATUS_W-1:0]   m_axis_tuser
);
  import bce_pkg::*;

  localparam int WW = COORD_BITS + 10;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int TW = PARAM_FRAC_BITS + 1;
  localparam int PW = 2 * COORD_BITS;
  localparam int X0 = IDX_W;
  localparam int Y0 = X0 + COORD_BITS;
  localparam int T0 = Y0 + COORD_BITS;
  localparam int O0 = T0 + TW;

  typedef enum logic [2:0] {IDLE, LOAD, LERP, RDOUT, RDWAIT, FIN} state_t;

  state_t state;

  // input fields
  logic [IDX_W-1:0]             in_idx;
  logic signed [COORD_BITS-1:0] in_x;
  logic signed [COORD_BITS-1:0] in_y;
  logic [TW-1:0]                in_t;
  logic [ORD_W-1:0]             in_ord;
  logic [ORD_W-1:0]             ord_eff;
  logic                         in_fire;

  assign in_idx  = s_axis_tdata[X0-1:0];
  assign in_x    = s_axis_tdata[Y0-1:X0];
  assign in_y    = s_axis_tdata[T0-1:Y0];
  assign in_t    = s_axis_tdata[O0-1:T0];
  assign in_ord  = s_axis_tdata[O0+ORD_W-1:O0];
  assign ord_eff = (in_ord == 2'd3) ? ORD_SECOND : in_ord;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state == IDLE);
  assign cfg_ready     = 1'b1;

  logic [CNT_W-1:0] point_count;
  logic [CW-1:0]    n_eff;
  logic [KW-1:0]    k_calc;

  // clamp the point count to the supported range
  always_comb begin
    if (point_count < 4'd2) begin
      n_eff = CW'(2);
    end else if (int'(point_count) > MAX_POINTS) begin
      n_eff = CW'(MAX_POINTS);
    end else begin
      n_eff = CW'(point_count);
    end
    case (ord_eff)
      ORD_POINT: k_calc = KW'(1);
      ORD_FIRST: k_calc = KW'(int'(n_eff) - 1);
      default:   k_calc = KW'((int'(n_eff) - 1) * (int'(n_eff) - 2));
    endcase
  end

  // working registers
  logic [CW-1:0]      n;
  logic [ORD_W-1:0]   ord;
  logic [TW-1:0]      t;
  logic [KW-1:0]      k;
  logic [CW-1:0]      m;
  logic [CW-1:0]      lvl;
  logic [CW-1:0]      rc;
  logic               same;
  logic [STATUS_W-1:0] status;
  logic signed [WW-1:0] res_x;
  logic signed [WW-1:0] res_y;

  // load pipeline
  logic               ld_v1;
  logic [CW-1:0]      ld_i1;
  logic               ld_v2;
  logic [CW-1:0]      ld_i2;
  logic [PW-1:0]      p0;
  logic signed [WW-1:0] p1_x, p1_y, p2_x, p2_y;
  logic signed [WW-1:0] d_x, d_y;

  // lerp sweep pipeline
  logic               lp_v1;
  logic [CW-1:0]      lp_i1;
  logic [CW-1:0]      ix_a;
  logic [CW-1:0]      ix_b;
  logic signed [WW-1:0] prev_x, prev_y;

  // memories
  logic               pt_we;
  logic [PW-1:0]      pt_rdata;
  logic               wk_we;
  logic [AW-1:0]      wk_waddr;
  logic [2*WW-1:0]    wk_wdata;
  logic [AW-1:0]      wk_raddr;
  logic [2*WW-1:0]    wk_rdata;

  logic signed [WW-1:0] cur_x, cur_y;
  logic signed [WW-1:0] wk_x, wk_y;
  logic                 lerp_in_v;
  logic                 lx_v, ly_v, lx_busy, ly_busy;
  logic signed [WW-1:0] lx_res, ly_res;
  logic                 ld_we, lp_we;

  assign pt_we = in_fire && (s_axis_tuser == OP_WRITE) && (int'(in_idx) < int'(n_eff));
  assign cur_x = WW'($signed(pt_rdata[COORD_BITS-1:0]));
  assign cur_y = WW'($signed(pt_rdata[PW-1:COORD_BITS]));
  assign wk_x  = wk_rdata[WW-1:0];
  assign wk_y  = wk_rdata[2*WW-1:WW];

  bce_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_points (
    .clk   (clk),
    .we    (pt_we),
    .waddr (AW'(in_idx)),
    .wdata ({in_y, in_x}),
    .raddr (AW'(rc)),
    .rdata (pt_rdata)
  );

  // work RAM write from either the load pass or the lerp sweep
  assign ld_we     = (state == LOAD) && ld_v2;
  assign lp_we     = lx_v;
  assign lerp_in_v = (state == LERP) && lp_v1 && (lp_i1 != '0);

  always_comb begin
    wk_we    = ld_we || lp_we;
    wk_waddr = AW'(ix_b);
    wk_wdata = {ly_res, lx_res};
    if (ld_we) begin
      wk_waddr = AW'(ld_i2);
      wk_wdata = {WW'(d_y * $signed({1'b0, k})), WW'(d_x * $signed({1'b0, k}))};
    end
    wk_raddr = (state == LERP) ? AW'(rc) : '0;
  end

  bce_ram #(.WIDTH(2 * WW), .DEPTH(MAX_POINTS)) u_work (
    .clk   (clk),
    .we    (wk_we),
    .waddr (wk_waddr),
    .wdata (wk_wdata),
    .raddr (wk_raddr),
    .rdata (wk_rdata)
  );

  bce_lerp #(.WW(WW), .FRAC(PARAM_FRAC_BITS)) u_lerp_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lerp_in_v),
    .a         (prev_x),
    .b         (wk_x),
    .t         (t),
    .out_valid (lx_v),
    .busy      (lx_busy),
    .result    (lx_res)
  );

  bce_lerp #(.WW(WW), .FRAC(PARAM_FRAC_BITS)) u_lerp_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lerp_in_v),
    .a         (prev_y),
    .b         (wk_y),
    .t         (t),
    .out_valid (ly_v),
    .busy      (ly_busy),
    .result    (ly_res)
  );

  // sequencer, pipelines and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      point_count   <= COUNT_RESET;
      m_axis_tvalid <= 1'b0;
      ld_v1         <= 1'b0;
      ld_v2         <= 1'b0;
      lp_v1         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        point_count <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready && (state != FIN)) begin
        m_axis_tvalid <= 1'b0;
      end
      ld_v1 <= (state == LOAD) && (rc < n);
      ld_v2 <= (state == LOAD) && ld_v1 && (ld_i1 >= CW'(ord));
      lp_v1 <= (state == LERP) && (rc <= lvl);
      unique case (state)
        IDLE: begin
          if (in_fire) begin
            res_x  <= '0;
            res_y  <= '0;
            n      <= n_eff;
            ord    <= ord_eff;
            t      <= in_t;
            k      <= k_calc;
            m      <= n_eff - CW'(ord_eff);
            rc     <= '0;
            same   <= 1'b1;
            if (s_axis_tuser == OP_WRITE) begin
              status <= pt_we ? ST_OK : ST_BAD_IDX;
              state  <= FIN;
            end else if (int'(in_t) > (1 << PARAM_FRAC_BITS)) begin
              status <= ST_T_RANGE;
              state  <= FIN;
            end else begin
              status <= ST_OK;
              state  <= LOAD;
            end
          end
        end
        LOAD: begin
          // issue point reads
          if (rc < n) begin
            ld_i1 <= rc;
            rc    <= rc + 1'b1;
          end
          // form differences from the point history
          if (ld_v1) begin
            if (ld_i1 == '0) begin
              p0 <= pt_rdata;
            end else if (pt_rdata != p0) begin
              same <= 1'b0;
            end
            p1_x <= cur_x;
            p1_y <= cur_y;
            p2_x <= p1_x;
            p2_y <= p1_y;
            case (ord)
              ORD_POINT: begin
                d_x <= cur_x;
                d_y <= cur_y;
              end
              ORD_FIRST: begin
                d_x <= cur_x - p1_x;
                d_y <= cur_y - p1_y;
              end
              default: begin
                d_x <= cur_x - (p1_x <<< 1) + p2_x;
                d_y <= cur_y - (p1_y <<< 1) + p2_y;
              end
            endcase
            ld_i2 <= ld_i1 - CW'(ord);
          end
          // move on once the pass has drained
          if ((rc == n) && !ld_v1 && !ld_v2) begin
            if (same) begin
              status <= ST_DEGEN;
            end
            rc  <= '0;
            lvl <= m - 1'b1;
            if (m >= CW'(2)) begin
              state <= LERP;
            end else if (m == CW'(1)) begin
              state <= RDOUT;
            end else begin
              state <= FIN;
            end
          end
        end
        LERP: begin
          // sweep one level: read j, lerp with j-1, write back j-1
          if (rc <= lvl) begin
            lp_i1 <= rc;
            rc    <= rc + 1'b1;
          end
          if (lp_v1) begin
            prev_x <= wk_x;
            prev_y <= wk_y;
            ix_a   <= lp_i1 - 1'b1;
          end
          ix_b <= ix_a;
          if ((rc > lvl) && !lp_v1 && !lx_busy && !ly_busy) begin
            rc  <= '0;
            lvl <= lvl - 1'b1;
            if (lvl == CW'(1)) begin
              state <= RDOUT;
            end
          end
        end
        RDOUT: begin
          state <= RDWAIT;
        end
        RDWAIT: begin
          res_x <= wk_x;
          res_y <= wk_y;
          state <= FIN;
        end
        FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {OUT_W'(res_y), OUT_W'(res_x)};
            m_axis_tuser  <= status;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `BCE_ASSERT_NXT(a_one_item, clk, rst, in_fire, !s_axis_tready, "item accepted while busy")
  `BCE_ASSERT_IMP(a_one_writer, clk, rst, ld_we, !lp_we, "work RAM written by two sources")
  `BCE_ASSERT_IMP(a_lerp_sync, clk, rst, 1'b1, lx_v == ly_v, "lerp lanes out of step")
  `BCE_ASSERT_IMP(a_range_zero, clk, rst, m_axis_tvalid && (m_axis_tuser == ST_T_RANGE), m_axis_tdata == '0, "out-of-range t gave nonzero data")
endmodule

// File: tb/bezier_curve_evaluator_core_tb.sv
// Testbench for the Bezier curve evaluator core: drives write and evaluate items,
// predicts each result with a behavioral de Casteljau model, checks the output stream.
// Depends on bce_pkg and the bezier_curve_evaluator_core RTL.
`timescale 1ns / 1ps

class curve_scoreboard;
  typedef struct {
    logic [47:0] rx;
    logic [47:0] ry;
    logic [1:0]  st;
  } curve_result_t;

  logic signed [63:0] pts [8][2];
  logic [3:0]         count;
  curve_result_t      pending [$];
  int                 errors;

  function new();
    count = bce_pkg::COUNT_RESET;
    errors = 0;
    for (int i = 0; i < 8; i++) begin
      pts[i][0] = 0;
      pts[i][1] = 0;
    end
  endfunction

  function int eff_count();
    if (count < 2) return 2;
    if (count > 8) return 8;
    return count;
  endfunction

  // a + round((b-a)*t), ties toward plus infinity
  function logic signed [63:0] lerp(logic signed [63:0] a, logic signed [63:0] b,
                                    logic [16:0] t);
    logic signed [63:0] p;
    p = (b - a) * $signed({47'd0, t}) + 64'sd32768;
    return a + (p >>> 16);
  endfunction

  function void note_input(logic op, logic [2:0] idx, logic [31:0] px, logic [31:0] py,
                           logic [16:0] t, logic [1:0] ord);
    curve_result_t r;
    logic signed [63:0] w [8][2];
    int n, m, k;
    logic same;
    n = eff_count();
    r.rx = 0;
    r.ry = 0;
    r.st = bce_pkg::ST_OK;
    if (op == bce_pkg::OP_WRITE) begin
      if (idx >= n) r.st = bce_pkg::ST_BAD_IDX;
      else begin
        pts[idx][0] = $signed(px);
        pts[idx][1] = $signed(py);
      end
    end else if (t > 17'd65536) begin
      r.st = bce_pkg::ST_T_RANGE;
    end else begin
      if (ord == 2'd3) ord = bce_pkg::ORD_SECOND;
      same = 1;
      for (int i = 1; i < n; i++)
        if (pts[i][0] != pts[0][0] || pts[i][1] != pts[0][1]) same = 0;
      if (same) r.st = bce_pkg::ST_DEGEN;
      m = n;
      if (ord == bce_pkg::ORD_SECOND && n == 2) m = 0;
      else if (ord == bce_pkg::ORD_POINT) begin
        for (int i = 0; i < n; i++) for (int c = 0; c < 2; c++) w[i][c] = pts[i][c];
      end else if (ord == bce_pkg::ORD_FIRST) begin
        m = n - 1;
        k = n - 1;
        for (int i = 0; i < m; i++) for (int c = 0; c < 2; c++)
          w[i][c] = (pts[i+1][c] - pts[i][c]) * k;
      end else begin
        m = n - 2;
        k = (n - 1) * (n - 2);
        for (int i = 0; i < m; i++) for (int c = 0; c < 2; c++)
          w[i][c] = (pts[i+2][c] - 2 * pts[i+1][c] + pts[i][c]) * k;
      end
      if (m > 0) begin
        for (int l = m - 1; l > 0; l--)
          for (int i = 0; i < l; i++) for (int c = 0; c < 2; c++)
            w[i][c] = lerp(w[i][c], w[i+1][c], t);
        r.rx = w[0][0][47:0];
        r.ry = w[0][1][47:0];
      end
    end
    pending = {pending, r};
  endfunction

  function void check_result(logic [47:0] rx, logic [47:0] ry, logic [1:0] st);
    curve_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result x=%h y=%h status=%0d", $time, rx, ry, st);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (rx !== e.rx || ry !== e.ry || st !== e.st) begin
      $display("%0t: mismatch expected x=%h y=%h status=%0d, actual x=%h y=%h status=%0d",
               $time, e.rx, e.ry, e.st, rx, ry, st);
      errors++;
    end
  endfunction
endclass

module bezier_curve_evaluator_core_tb;
  import bce_pkg::*;

  localparam int DIN_W = 88;

  logic              clk = 0;
  logic              rst = 1;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data = 0;
  logic              s_axis_tvalid = 0;
  logic              s_axis_tready;
  // point_index, point_x, point_y, param_t, deriv_order, zero fill
  logic [DIN_W-1:0]  s_axis_tdata = 0;
  // opcode
  logic              s_axis_tuser = 0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 0;
  // result_x, result_y
  logic [2*OUT_W-1:0] m_axis_tdata;
  // status
  logic [STATUS_W-1:0] m_axis_tuser;

  curve_scoreboard sb = new();
  logic            hold_off = 0;

  bezier_curve_evaluator_core dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Send one item; wait through the handshake, keep valid up for a follow-on item
  task automatic send_item(logic op, logic [2:0] idx, logic [31:0] px, logic [31:0] py,
                           logic [16:0] t, logic [1:0] ord, logic quiet);
    int g;
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'd0, ord, t, py, px, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(op, idx, px, py, t, ord);
    @(negedge clk);
  endtask

  // Write the count register once the block has drained
  task automatic set_count(logic [3:0] v);
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_valid <= 1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.count = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 511) - 256);
      default: return $urandom;
    endcase
  endfunction

  function logic [16:0] rand_t();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // Fill every point in use, then evaluate at random, with some writes mixed in
  task automatic run_phase(logic [3:0] cnt, int items);
    int n;
    logic [31:0] same_x, same_y;
    logic degen;
    set_count(cnt);
    n = sb.eff_count();
    degen = ($urandom_range(0, 7) == 0);
    same_x = rand_coord();
    same_y = rand_coord();
    for (int i = 0; i < n; i++)
      send_item(OP_WRITE, 3'(i), degen ? same_x : rand_coord(),
                degen ? same_y : rand_coord(), 17'($urandom), 2'($urandom), 0);
    for (int j = 0; j < items; j++) begin
      if ($urandom_range(0, 5) == 0)
        send_item(OP_WRITE, 3'($urandom_range(0, 7)), rand_coord(), rand_coord(),
                  17'($urandom), 2'($urandom), 0);
      else
        send_item(OP_EVAL, 3'($urandom), $urandom, $urandom, rand_t(), 2'($urandom), 0);
    end
  endtask

  // Receiver: random stalls, sample at the rising edge
  initial begin
    int g;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      g = hold_off ? 0 : gap_len();
      m_axis_tready <= 0;
      repeat (g) @(negedge clk);
      while (hold_off) @(negedge clk);
      m_axis_tready <= 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      sb.check_result(m_axis_tdata[OUT_W-1:0], m_axis_tdata[2*OUT_W-1:OUT_W], m_axis_tuser);
      @(negedge clk);
    end
  end

  // Limit
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [3:0] counts [10] = '{4'd2, 4'd8, 4'd3, 4'd0, 4'd15, 4'd5, 4'd4, 4'd7, 4'd6, 4'd1};
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: extremes, bad index, out of range t, degenerate, order three
    set_count(4'd3);
    send_item(OP_WRITE, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
    send_item(OP_WRITE, 1, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
    send_item(OP_WRITE, 2, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
    send_item(OP_WRITE, 3, 32'h1, 32'h1, 0, 0, 0);
    send_item(OP_WRITE, 7, 32'hffff_ffff, 32'hffff_ffff, 17'h1ffff, 2'd3, 0);
    for (int o = 0; o < 4; o++) begin
      send_item(OP_EVAL, 0, 0, 0, 17'd0, 2'(o), 0);
      send_item(OP_EVAL, 0, 0, 0, 17'd65536, 2'(o), 0);
      send_item(OP_EVAL, 0, 0, 0, 17'd32768, 2'(o), 0);
    end
    send_item(OP_EVAL, 0, 0, 0, 17'd65537, 0, 0);
    send_item(OP_EVAL, 7, 32'hffff_ffff, 32'hffff_ffff, 17'h1ffff, 1, 0);
    for (int i = 0; i < 3; i++)
      send_item(OP_WRITE, 3'(i), 32'h0001_0000, 32'hfffe_0000, 0, 0, 0);
    send_item(OP_EVAL, 0, 0, 0, 17'd12345, 0, 0);
    send_item(OP_EVAL, 0, 0, 0, 17'd70000, 0, 0);

    // Stall the output long enough to back up the input
    hold_off <= 1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off <= 0;
      end
      for (int i = 0; i < 4; i++) send_item(OP_EVAL, 0, 0, 0, rand_t(), 2'($urandom), 1);
    join

    foreach (counts[i]) run_phase(counts[i], 155);

    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
